/* src/mbp_pkg.sv */
// shared types, constants and boundary lookup functions for the multipart body parser
// no dependencies
package mbp_pkg;

    localparam int MAX_BOUNDARY = 48;
    localparam int BND_WORDS = 6;
    localparam int BND_BYTES = BND_WORDS * 8;
    localparam int LEN_W = 6;
    localparam int MATCH_W = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_WORD_5 = 3'd6;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_DASH = 8'h2d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef logic [BND_BYTES-1:0][7:0] bnd_bytes_t;

    typedef enum logic [2:0] {
        K_NAME        = 3'd0,
        K_NAME_END    = 3'd1,
        K_VALUE       = 3'd2,
        K_VALUE_END   = 3'd3,
        K_CONTENT     = 3'd4,
        K_CONTENT_END = 3'd5,
        K_BODY_END    = 3'd6,
        K_ERROR       = 3'd7
    } kind_t;

    typedef enum logic [14:0] {
        ST_DASH1      = 15'b000000000000001,
        ST_DASH2      = 15'b000000000000010,
        ST_BOUND      = 15'b000000000000100,
        ST_OPEN_CR    = 15'b000000000001000,
        ST_OPEN_LF    = 15'b000000000010000,
        ST_HDR        = 15'b000000000100000,
        ST_HDR_CR     = 15'b000000001000000,
        ST_NAME       = 15'b000000010000000,
        ST_SKIPSP     = 15'b000000100000000,
        ST_VALUE      = 15'b000001000000000,
        ST_VAL_CR     = 15'b000010000000000,
        ST_VAL_END    = 15'b000100000000000,
        ST_VAL_END_CR = 15'b001000000000000,
        ST_CONTENT    = 15'b010000000000000,
        ST_END        = 15'b100000000000000
    } state_t;

    // work left behind by one input word: replayed delimiter bytes, then up to two tail results
    typedef struct packed {
        logic [MATCH_W-1:0] rep;
        logic [7:0]         rep_tail;
        logic [1:0]         tails;
        kind_t              k0;
        logic [7:0]         d0;
        kind_t              k1;
    } job_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    function automatic logic [7:0] bnd_byte(input bnd_bytes_t bnd, input logic [5:0] idx);
        logic [7:0] r;
        r = 8'h00;
        if (idx < 6'(BND_BYTES))
        begin
            r = bnd[idx];
        end
        return r;
    endfunction

    function automatic logic [7:0] delim_byte(input bnd_bytes_t bnd, input logic [5:0] k);
        logic [7:0] r;
        if (k == 6'd0)
        begin
            r = CH_CR;
        end
        else if (k == 6'd1)
        begin
            r = CH_LF;
        end
        else if (k < 6'd4)
        begin
            r = CH_DASH;
        end
        else
        begin
            r = bnd_byte(bnd, k - 6'd4);
        end
        return r;
    endfunction

endpackage

/* src/mbp_cfg_regs.sv */
// boundary length and boundary string registers with length clamping
// depends on mbp_pkg
module mbp_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [mbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                    cfg_wr_data,
    output logic [mbp_pkg::LEN_W-1:0]      eff_len,
    output mbp_pkg::bnd_bytes_t            bnd
);
    import mbp_pkg::*;

    logic [LEN_W-1:0]               len_reg;
    logic [BND_WORDS-1:0][63:0]     word_reg;
    logic [CFG_IDX_W-1:0]           word_idx;

    assign word_idx = cfg_index - CFG_BOUNDARY_WORD_0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_W'(1);
            word_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_BOUNDARY_LENGTH)
            begin
                len_reg <= cfg_wr_data[LEN_W-1:0];
            end
            else if (cfg_index <= CFG_BOUNDARY_WORD_5)
            begin
                word_reg[word_idx] <= cfg_wr_data;
            end
        end
    end

    always_comb
    begin
        eff_len = len_reg;
        if (len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_BOUNDARY))
        begin
            eff_len = LEN_W'(MAX_BOUNDARY);
        end
    end

    assign bnd = word_reg;

endmodule

/* src/mbp_parser.sv */
// framing FSM: decodes one body byte per job_ready cycle into a job for the emitter
// depends on mbp_pkg
module mbp_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_byte,
    input  logic [mbp_pkg::LEN_W-1:0]  eff_len,
    input  mbp_pkg::bnd_bytes_t        bnd,
    output logic                       job_valid,
    input  logic                       job_ready,
    output mbp_pkg::job_t              job
);
    import mbp_pkg::*;

    state_t               st_reg, st_next;
    logic [MATCH_W-1:0]   m_reg, m_next;
    logic                 twd_reg, twd_next;
    logic                 err_reg, err_next;
    logic                 accept;
    logic                 name_go, value_go, do_fail;
    logic                 hit, end_hit;
    logic [MATCH_W-1:0]   mc, m1;
    logic [MATCH_W:0]     len4;

    assign in_ready = job_ready;
    assign accept = in_valid && job_ready;
    assign len4 = {1'b0, eff_len} + 7'd4;
    assign m1 = m_reg + 6'd1;

    always_comb
    begin
        st_next  = st_reg;
        m_next   = m_reg;
        twd_next = twd_reg;
        err_next = err_reg;
        job      = '0;
        name_go  = 1'b0;
        value_go = 1'b0;
        do_fail  = 1'b0;
        hit      = 1'b0;
        end_hit  = 1'b0;
        mc       = m_reg;
        if (err_reg)
        begin
            job.tails = 2'd1;
            job.k0    = K_ERROR;
        end
        else
        begin
            unique case (st_reg)
                ST_DASH1:
                begin
                    if (in_byte != CH_DASH) do_fail = 1'b1;
                    else st_next = ST_DASH2;
                end
                ST_DASH2:
                begin
                    if (in_byte != CH_DASH)
                    begin
                        do_fail = 1'b1;
                    end
                    else
                    begin
                        st_next = ST_BOUND;
                        m_next  = '0;
                    end
                end
                ST_BOUND:
                begin
                    if (in_byte != bnd_byte(bnd, m_reg))
                    begin
                        do_fail = 1'b1;
                    end
                    else if (m1 >= eff_len)
                    begin
                        m_next  = '0;
                        st_next = ST_OPEN_CR;
                    end
                    else
                    begin
                        m_next = m1;
                    end
                end
                ST_OPEN_CR:
                begin
                    if (in_byte != CH_CR) do_fail = 1'b1;
                    else st_next = ST_OPEN_LF;
                end
                ST_OPEN_LF:
                begin
                    if (in_byte != CH_LF) do_fail = 1'b1;
                    else st_next = ST_HDR;
                end
                ST_HDR:
                begin
                    if (in_byte == CH_CR) st_next = ST_HDR_CR;
                    else name_go = 1'b1;
                end
                ST_HDR_CR:
                begin
                    if (in_byte == CH_LF)
                    begin
                        st_next = ST_CONTENT;
                        m_next  = '0;
                    end
                    else
                    begin
                        name_go = 1'b1;
                    end
                end
                ST_NAME:
                begin
                    name_go = 1'b1;
                end
                ST_SKIPSP:
                begin
                    if (in_byte != CH_SPACE) value_go = 1'b1;
                end
                ST_VALUE:
                begin
                    value_go = 1'b1;
                end
                ST_VAL_CR:
                begin
                    if (in_byte != CH_LF)
                    begin
                        do_fail = 1'b1;
                    end
                    else
                    begin
                        job.tails = 2'd1;
                        job.k0    = K_VALUE_END;
                        st_next   = ST_VAL_END;
                    end
                end
                ST_VAL_END:
                begin
                    if (in_byte == CH_CR) st_next = ST_VAL_END_CR;
                    else name_go = 1'b1;
                end
                ST_VAL_END_CR:
                begin
                    if (in_byte == CH_LF)
                    begin
                        st_next = ST_CONTENT;
                        m_next  = '0;
                    end
                    else if (in_byte == CH_CR)
                    begin
                        st_next = ST_HDR_CR;
                    end
                    else
                    begin
                        name_go = 1'b1;
                    end
                end
                ST_CONTENT:
                begin
                    // a position left beyond a shortened delimiter is dropped
                    if ({1'b0, m_reg} > len4 + 7'd1) mc = '0;
                    if ({1'b0, mc} < len4)
                    begin
                        hit = (in_byte == delim_byte(bnd, mc));
                    end
                    else if ({1'b0, mc} == len4)
                    begin
                        hit = (in_byte == CH_CR) || (in_byte == CH_DASH);
                        if (hit) twd_next = (in_byte == CH_DASH);
                    end
                    else
                    begin
                        end_hit = (in_byte == (twd_reg ? CH_DASH : CH_LF));
                    end
                    if (end_hit)
                    begin
                        m_next    = '0;
                        job.k0    = K_CONTENT_END;
                        job.k1    = K_BODY_END;
                        job.tails = twd_reg ? 2'd2 : 2'd1;
                        st_next   = twd_reg ? ST_END : ST_HDR;
                    end
                    else if (hit)
                    begin
                        m_next = mc + 6'd1;
                    end
                    else
                    begin
                        job.rep      = mc;
                        job.rep_tail = twd_reg ? CH_DASH : CH_CR;
                        if (in_byte == CH_CR)
                        begin
                            m_next = 6'd1;
                        end
                        else
                        begin
                            m_next    = '0;
                            job.tails = 2'd1;
                            job.k0    = K_CONTENT;
                            job.d0    = in_byte;
                        end
                    end
                end
                ST_END:
                begin
                end
                default:
                begin
                    do_fail = 1'b1;
                end
            endcase
        end

        if (name_go)
        begin
            job.tails = 2'd1;
            if (in_byte == CH_COLON)
            begin
                job.k0  = K_NAME_END;
                st_next = ST_SKIPSP;
            end
            else
            begin
                job.k0  = K_NAME;
                job.d0  = in_byte;
                st_next = ST_NAME;
            end
        end
        if (value_go)
        begin
            if (in_byte == CH_CR)
            begin
                st_next = ST_VAL_CR;
            end
            else
            begin
                job.tails = 2'd1;
                job.k0    = K_VALUE;
                job.d0    = in_byte;
                st_next   = ST_VALUE;
            end
        end
        if (do_fail)
        begin
            err_next  = 1'b1;
            job.tails = 2'd1;
            job.k0    = K_ERROR;
        end
    end

    assign job_valid = accept && ((job.rep != '0) || (job.tails != 2'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_DASH1;
            m_reg   <= '0;
            twd_reg <= 1'b0;
            err_reg <= 1'b0;
        end
        else if (accept)
        begin
            st_reg  <= st_next;
            m_reg   <= m_next;
            twd_reg <= twd_next;
            err_reg <= err_next;
        end
    end

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("sticky error cleared");

    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_reg <= MATCH_W'(MAX_BOUNDARY + 5))
        else $error("match position beyond delimiter");
`endif

endmodule

/* src/mbp_emitter.sv */
// walks one job at a time: replayed delimiter bytes first, then the tail results
// depends on mbp_pkg
module mbp_emitter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  mbp_pkg::job_t              job,
    input  logic [mbp_pkg::LEN_W-1:0]  eff_len,
    input  mbp_pkg::bnd_bytes_t        bnd,
    output logic                       res_valid,
    input  logic                       res_ready,
    output mbp_pkg::result_t           res
);
    import mbp_pkg::*;

    logic                 busy_reg;
    job_t                 job_reg;
    logic [MATCH_W-1:0]   pos_reg;
    logic                 tpos_reg;
    logic                 in_rep, fin, issue;

    assign in_rep = pos_reg < job_reg.rep;
    assign issue = busy_reg && res_ready;
    assign res_valid = busy_reg;
    assign job_ready = !busy_reg || (issue && fin);

    always_comb
    begin
        res = '0;
        fin = 1'b0;
        if (in_rep)
        begin
            res.kind = K_CONTENT;
            if ({1'b0, pos_reg} < {1'b0, eff_len} + 7'd4)
            begin
                res.data = delim_byte(bnd, pos_reg);
            end
            else
            begin
                res.data = job_reg.rep_tail;
            end
            fin = ({1'b0, pos_reg} + 7'd1 == {1'b0, job_reg.rep}) && (job_reg.tails == 2'd0);
        end
        else if (!tpos_reg)
        begin
            res.kind = job_reg.k0;
            res.data = job_reg.d0;
            fin      = (job_reg.tails == 2'd1);
        end
        else
        begin
            res.kind = job_reg.k1;
            fin      = 1'b1;
        end
        res.last = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
            tpos_reg <= 1'b0;
        end
        else if (job_valid && job_ready)
        begin
            busy_reg <= 1'b1;
            pos_reg  <= '0;
            tpos_reg <= 1'b0;
        end
        else if (issue && fin)
        begin
            busy_reg <= 1'b0;
        end
        else if (issue)
        begin
            if (in_rep) pos_reg <= pos_reg + 6'd1;
            else tpos_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            job_reg <= job;
        end
    end

`ifndef SYNTHESIS
    a_job_taken: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> job_ready)
        else $error("job offered while emitter busy");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg <= job_reg.rep))
        else $error("replay position past replay count");

    a_no_empty_job: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (job_reg.tails == 2'd0)) |-> (job_reg.rep != '0))
        else $error("job without results");
`endif

endmodule

/* src/mbp_out_skid.sv */
// two-entry output queue that registers both sides of the result stream
// depends on mbp_pkg
module mbp_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mbp_pkg::result_t  in_res,
    output logic              out_valid,
    input  logic              out_ready,
    output mbp_pkg::result_t  out_res
);
    import mbp_pkg::*;

    logic [1:0]   cnt_reg;
    result_t      slot0_reg, slot1_reg;
    logic         push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_res = slot0_reg;
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            if (cnt_reg == 2'd0) slot0_reg <= in_res;
            else slot1_reg <= in_res;
        end
        else if (pop && !push)
        begin
            slot0_reg <= slot1_reg;
        end
        else if (pop && push)
        begin
            if (cnt_reg == 2'd1) slot0_reg <= in_res;
            else
            begin
                slot0_reg <= slot1_reg;
                slot1_reg <= in_res;
            end
        end
    end

endmodule

/* src/multipart_body_parser_unit.sv */
// top level of the multipart body parser
// depends on mbp_pkg, mbp_cfg_regs, mbp_parser, mbp_emitter, mbp_out_skid
//
// Takes a multipart body one byte per word and emits tagged words: header name bytes, name
// end, value bytes, value end, content bytes, content end, body end and error, with tlast
// on the final word caused by each input byte. An input byte is taken every cycle as long
// as the result stream keeps up; a byte that yields several words (a content delimiter
// that fails partway and is replayed as content, or content end plus body end) holds the
// input until its last word goes out (boundary length plus six words at most); the emitter
// issues one word per cycle when accepted. The user must write boundary registers through
// the cfg port only while the parser is idle (unenforced); no clearing pass follows reset.
module multipart_body_parser_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // data_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // data
    output logic [2:0]                        m_axis_tuser,   // kind
    output logic                              m_axis_tlast,
    input  logic                              cfg_wr_en,
    input  logic [mbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                       cfg_wr_data
);
    import mbp_pkg::*;

    logic [LEN_W-1:0]   eff_len;
    bnd_bytes_t         bnd;
    logic               job_valid, job_ready;
    job_t               job;
    logic               res_valid, res_ready;
    result_t            res, out_res;

    mbp_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .eff_len     (eff_len),
        .bnd         (bnd)
    );

    mbp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .eff_len   (eff_len),
        .bnd       (bnd),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    mbp_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .eff_len   (eff_len),
        .bnd       (bnd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    mbp_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.data;
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule
